@@ rtl/ljpf_pkg.sv @@
// Shared types, register codes, operation codes and reset values
// for the Lennard-Jones pair force block. Depends on nothing.
package ljpf_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;

  localparam logic [2:0] CFG_BOX    = 3'd0;
  localparam logic [2:0] CFG_CUTOFF = 3'd1;
  localparam logic [2:0] CFG_EPS    = 3'd2;
  localparam logic [2:0] CFG_SIGMA6 = 3'd3;
  localparam logic [2:0] CFG_ESHIFT = 3'd4;

  localparam logic [30:0] BOX_RST    = 31'd655360;
  localparam logic [30:0] CUTOFF_RST = 31'd163840;
  localparam logic [31:0] EPS_RST    = 32'd65536;
  localparam logic [47:0] SIGMA6_RST = 48'd65536;
  localparam logic [47:0] ESHIFT_RST = 48'hFFFF_FFFB_D2AC;  // -273748

  // Multiply operations, in the order the controller issues them.
  localparam logic [3:0] OP_RC2  = 4'd0;
  localparam logic [3:0] OP_SQ0  = 4'd1;
  localparam logic [3:0] OP_SQ1  = 4'd2;
  localparam logic [3:0] OP_SQ2  = 4'd3;
  localparam logic [3:0] OP_I2SQ = 4'd4;
  localparam logic [3:0] OP_I6   = 4'd5;
  localparam logic [3:0] OP_U    = 4'd6;
  localparam logic [3:0] OP_UU   = 4'd7;
  localparam logic [3:0] OP_EM   = 4'd8;
  localparam logic [3:0] OP_GM   = 4'd9;
  localparam logic [3:0] OP_K    = 4'd10;
  localparam logic [3:0] OP_F0   = 4'd11;
  localparam logic [3:0] OP_F1   = 4'd12;
  localparam logic [3:0] OP_F2   = 4'd13;

  typedef struct packed {
    logic               clear_sums;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               within_cutoff;
    logic signed [63:0] energy_total;
    logic signed [63:0] virial_total;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       wrap;
    logic       mul_start;
    logic       mul_commit;
    logic [3:0] op;
    logic       cmp;
    logic       div_start;
    logic       div_commit;
    logic       acc;
  } cmd_t;

  typedef struct packed {
    logic r2_ok;
    logic mul_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/ljpf_mul.sv @@
// 64 by 64 multiplier built from one 32 by 32 multiplier that forms and sums the partial products in turn.
// Uses no package items.
module ljpf_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r, b_r;
  logic [1:0]   cnt;
  logic         busy;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_shift;

  always_comb begin
    a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
    b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
    pp = 64'(a_part) * 64'(b_part);
    pp_shift = {64'd0, pp} << (7'(cnt[0]) + 7'(cnt[1])) * 7'd32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_shift;
    end
  end

endmodule

@@ rtl/ljpf_div.sv @@
// Restoring divider for floor(2^K / d), one quotient bit per cycle,
// saturating at all ones. Uses no package items.
module ljpf_div #(
  parameter int K = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] d,
  output logic        done,
  output logic [63:0] q_out,
  output logic        sat
);

  localparam int CW = $clog2(K + 1);
  localparam logic [CW-1:0] KTOP = CW'(K);

  logic [63:0]   d_r, rem, q;
  logic          ovf, busy;
  logic [CW-1:0] cnt;
  logic [64:0]   t;
  logic          ge;

  always_comb begin
    t  = {rem, cnt == KTOP};
    ge = t >= {1'b0, d_r};
    sat = ovf || (d_r == 64'd0);
    q_out = sat ? '1 : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KTOP;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= d;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      logic [64:0] diff;
      diff = t - {1'b0, d_r};
      rem <= ge ? diff[63:0] : t[63:0];
      q   <= {q[62:0], ge};
      // A set top bit that is about to shift out means the quotient overflows.
      if (q[63]) ovf <= 1'b1;
    end
  end

endmodule

@@ rtl/ljpf_dp.sv @@
// Datapath: configuration registers, wrap, shared multiplier and divider,
// energy and virial sums, output register. Depends on ljpf_pkg, ljpf_mul, ljpf_div.
module ljpf_dp #(
  parameter int POS_FRAC_BITS = ljpf_pkg::POS_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  ljpf_pkg::in_t   in_data,
  input  ljpf_pkg::cmd_t  cmd,
  output ljpf_pkg::stat_t stat,
  input  logic            out_stall,
  output logic            out_valid,
  output ljpf_pkg::out_t  out_data
);
  import ljpf_pkg::*;

  localparam int FSH = 8 + POS_FRAC_BITS;
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, 63'd0};
  localparam logic [63:0] F47_MAX = {17'd0, {47{1'b1}}};

  logic [30:0] box_length, cutoff_radius;
  logic [31:0] well_depth;
  logic [47:0] sigma_sixth, energy_shift;

  in_t          in_r;
  logic [33:0]  d [3];
  logic [33:0]  mag [3];
  logic         axis_ok, in_cut, sat;
  logic [63:0]  r2, rc2, i2, i2sq, i6, u, uu, twouu, e4, c24, k;
  logic [63:0]  epair, vpair, energy_sum, virial_sum;
  logic [47:0]  fvec [3];

  logic [63:0]  ma, mb, mres;
  logic [127:0] prod, sh_prod;
  logic         mul_done, msat;
  logic         div_done, div_sat;
  logic [63:0]  div_q;

  logic         eneg, gneg;
  logic [63:0]  em, gm;

  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = {1'b1, s[64] ? S64_MIN : S64_MAX};
    else sadd = {1'b0, s[63:0]};
  endfunction

  // Clamp a magnitude to a limit and apply a sign; the top bit flags the clamp.
  function automatic logic [64:0] sgn_of(input logic [63:0] m, input logic neg,
                                         input logic [63:0] lim);
    logic [63:0] v;
    logic        over;
    over = m > lim;
    v = over ? lim : m;
    sgn_of = {over, neg ? -v : v};
  endfunction

  ljpf_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(ma), .b(mb),
    .done(mul_done), .prod(prod)
  );

  ljpf_div #(.K(32 + 2 * POS_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .d(r2),
    .done(div_done), .q_out(div_q), .sat(div_sat)
  );

  always_comb begin
    eneg = uu < u;
    em   = eneg ? u - uu : uu - u;
    gneg = twouu < u;
    gm   = gneg ? u - twouu : twouu - u;
  end

  always_comb begin
    ma = 64'(cutoff_radius);
    mb = 64'(cutoff_radius);
    sh_prod = prod;
    unique case (cmd.op)
      OP_RC2:  begin ma = 64'(cutoff_radius); mb = 64'(cutoff_radius); end
      OP_SQ0:  begin ma = 64'(mag[0]); mb = 64'(mag[0]); end
      OP_SQ1:  begin ma = 64'(mag[1]); mb = 64'(mag[1]); end
      OP_SQ2:  begin ma = 64'(mag[2]); mb = 64'(mag[2]); end
      OP_I2SQ: begin ma = i2; mb = i2; sh_prod = prod >> 32; end
      OP_I6:   begin ma = i2sq; mb = i2; sh_prod = prod >> 32; end
      OP_U:    begin ma = 64'(sigma_sixth); mb = i6; sh_prod = prod >> 16; end
      OP_UU:   begin ma = u; mb = u; sh_prod = prod >> 32; end
      OP_EM:   begin ma = 64'(well_depth); mb = em; sh_prod = prod >> 16; end
      OP_GM:   begin ma = 64'(well_depth); mb = gm; sh_prod = prod >> 16; end
      OP_K:    begin ma = c24; mb = i2; sh_prod = prod >> 32; end
      OP_F0:   begin ma = k; mb = 64'(mag[0]); sh_prod = prod >> FSH; end
      OP_F1:   begin ma = k; mb = 64'(mag[1]); sh_prod = prod >> FSH; end
      OP_F2:   begin ma = k; mb = 64'(mag[2]); sh_prod = prod >> FSH; end
      default: begin ma = '0; mb = '0; end
    endcase
    msat = |sh_prod[127:64];
    mres = msat ? '1 : sh_prod[63:0];
  end

  always_comb begin
    stat.r2_ok    = axis_ok && (r2 <= rc2);
    stat.mul_done = mul_done;
    stat.div_done = div_done;
    stat.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length    <= BOX_RST;
      cutoff_radius <= CUTOFF_RST;
      well_depth    <= EPS_RST;
      sigma_sixth   <= SIGMA6_RST;
      energy_shift  <= ESHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX:    box_length    <= cfg_data[30:0];
        CFG_CUTOFF: cutoff_radius <= cfg_data[30:0];
        CFG_EPS:    well_depth    <= cfg_data[31:0];
        CFG_SIGMA6: sigma_sixth   <= cfg_data[47:0];
        CFG_ESHIFT: energy_shift  <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
      sat  <= 1'b0;
    end
    if (cmd.wrap) begin
      logic signed [35:0] df [3];
      logic signed [35:0] len, dw;
      logic ok;
      df[0] = 36'(in_r.second_x) - 36'(in_r.first_x);
      df[1] = 36'(in_r.second_y) - 36'(in_r.first_y);
      df[2] = 36'(in_r.second_z) - 36'(in_r.first_z);
      len = $signed({5'd0, box_length});
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        dw = df[i];
        if ((df[i] <<< 1) < -len) dw = df[i] + len;
        else if ((df[i] <<< 1) > len) dw = df[i] - len;
        d[i]   <= dw[33:0];
        mag[i] <= dw[35] ? 34'(-dw) : dw[33:0];
        if ((dw[35] ? 36'(-dw) : 36'(dw)) > 36'(cutoff_radius)) ok = 1'b0;
      end
      axis_ok <= ok;
      r2 <= '0;
    end
    if (cmd.cmp) in_cut <= stat.r2_ok;
    if (cmd.div_commit) begin
      i2 <= div_q;
      if (div_sat) sat <= 1'b1;
    end
    if (cmd.mul_commit) begin
      logic hit;
      // The distance products can exceed 64 bits for a pair already outside.
      hit = (cmd.op >= OP_I2SQ) && msat;
      unique case (cmd.op)
        OP_RC2: rc2 <= prod[63:0];
        OP_SQ0, OP_SQ1, OP_SQ2: r2 <= r2 + prod[63:0];
        OP_I2SQ: i2sq <= mres;
        OP_I6:   i6 <= mres;
        OP_U:    u <= mres;
        OP_UU: begin
          uu <= mres;
          twouu <= mres[63] ? '1 : {mres[62:0], 1'b0};
          if (mres[63]) hit = 1'b1;
        end
        OP_EM: begin
          e4 <= (|mres[63:62]) ? '1 : {mres[61:0], 2'b00};
          if (|mres[63:62]) hit = 1'b1;
        end
        OP_GM: begin
          logic [68:0] p24;
          logic [64:0] so, sa;
          logic [63:0] nshift;
          p24 = ({5'd0, mres} << 4) + ({5'd0, mres} << 3);
          c24 <= (|p24[68:64]) ? '1 : p24[63:0];
          so = sgn_of(e4, eneg, S64_MAX);
          nshift = -({{16{energy_shift[47]}}, energy_shift} << 8);
          sa = sadd(so[63:0], nshift);
          epair <= sa[63:0];
          if ((|p24[68:64]) || so[64] || sa[64]) hit = 1'b1;
        end
        OP_K: begin
          logic [64:0] vo;
          k <= mres;
          vo = sgn_of(c24, !gneg, S64_MAX);
          vpair <= vo[63:0];
          if (vo[64]) hit = 1'b1;
        end
        OP_F0, OP_F1, OP_F2: begin
          logic [64:0] fo;
          logic [1:0] ax;
          ax = 2'(cmd.op - OP_F0);
          fo = sgn_of(mres, (!gneg) != d[ax][33], F47_MAX);
          fvec[ax] <= fo[47:0];
          if (fo[64]) hit = 1'b1;
        end
        default: ;
      endcase
      if (hit) sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum <= '0;
      virial_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.acc) begin
        logic [63:0] be, bv;
        logic [64:0] se, sv;
        be = in_r.clear_sums ? '0 : energy_sum;
        bv = in_r.clear_sums ? '0 : virial_sum;
        se = sadd(be, epair);
        sv = sadd(bv, vpair);
        if (in_cut) begin
          be = se[63:0];
          bv = sv[63:0];
        end
        energy_sum <= be;
        virial_sum <= bv;
        out_valid  <= 1'b1;
        out_data.force_x       <= in_cut ? fvec[0] : '0;
        out_data.force_y       <= in_cut ? fvec[1] : '0;
        out_data.force_z       <= in_cut ? fvec[2] : '0;
        out_data.within_cutoff <= in_cut;
        out_data.energy_total  <= be;
        out_data.virial_total  <= bv;
        out_data.saturated     <= in_cut && (sat || se[64] || sv[64]);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/ljpf_ctrl.sv @@
// Controller: sequences wrap, the multiply operations and the reciprocal
// for one pair at a time. Depends on ljpf_pkg.
module ljpf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ljpf_pkg::stat_t stat,
  output ljpf_pkg::cmd_t  cmd
);
  import ljpf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRAP   = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DWAIT  = 3'd6;
  localparam logic [2:0] S_ACC    = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] op, op_next;

  always_comb begin
    state_next = state;
    op_next = op;
    cmd = '0;
    cmd.op = op;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
        op_next = OP_RC2;
        state_next = S_MSTART;
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_next = S_MWAIT;
      end
      S_MWAIT: if (stat.mul_done) begin
        cmd.mul_commit = 1'b1;
        op_next = op + 4'd1;
        if (op == OP_SQ2) state_next = S_CMP;
        else if (op == OP_F2) state_next = S_ACC;
        else state_next = S_MSTART;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = stat.r2_ok ? S_DSTART : S_ACC;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: if (stat.div_done) begin
        cmd.div_commit = 1'b1;
        op_next = OP_I2SQ;
        state_next = S_MSTART;
      end
      S_ACC: if (stat.out_free) begin
        cmd.acc = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_RC2;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

`ifndef SYNTH
  a_mul_only_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> state == S_MWAIT) else $error("multiplier done while not waiting");
  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_DWAIT) else $error("divider done while not waiting");
  a_load_then_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_WRAP) else $error("accepted pair not wrapped next");
`endif

endmodule

@@ rtl/lj_pair_force_periodic.sv @@
// Top level of the Lennard-Jones 12-6 pair force block with minimum-image wrap.
// Depends on ljpf_pkg, ljpf_ctrl and ljpf_dp.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_data (in_t)
//   out      output     out_valid / out_stall out_data (out_t)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pair inside the cutoff needs the reciprocal, formed one quotient bit per cycle,
// and fourteen 64-bit products, each summed from partial products of the one
// shared 32x32 multiplier. A pair outside the cutoff skips the reciprocal and
// all products after the first four.
// Reset is synchronous and restores the register defaults and zero sums.
// A finished result waits in the output register while the next pair is taken;
// a result still stalled there holds the following pair in its last step.
module lj_pair_force_periodic #(
  parameter int POS_FRAC_BITS = ljpf_pkg::POS_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ljpf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ljpf_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data
);
  import ljpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ljpf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  ljpf_dp #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_data(in_data),
    .cmd(cmd), .stat(stat), .out_stall(out_stall),
    .out_valid(out_valid), .out_data(out_data)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second pair taken while busy");
  a_outside_no_force: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.within_cutoff) |->
      (out_data.force_x == 0 && out_data.force_y == 0 && out_data.force_z == 0))
    else $error("force reported outside cutoff");
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall)) else $error("result with no pair in work");
`endif

endmodule

@@ test/lj_pair_force_periodic_test.sv @@
// Self-checking testbench for lj_pair_force_periodic: random and directed atom pairs,
// a bit-accurate force and energy predictor, and random idling on both channels.
// Depends on ljpf_pkg and the lj_pair_force_periodic RTL.
`timescale 1ns / 100ps

module lj_pair_force_periodic_test;
  import ljpf_pkg::*;

  localparam int  PFB        = POS_FRAC_BITS_DEF;
  localparam int  CYCLE_CAP  = 4000000;
  localparam int  PER_PHASE  = 325;
  localparam logic [63:0] S64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] F47MAX = 64'h0000_7FFF_FFFF_FFFF;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t  in_data;
  out_t out_data;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  lj_pair_force_periodic i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the running sums.
  logic [30:0] box_len, cut_rad;
  logic [31:0] eps_q;
  logic [47:0] sig6_q;
  longint      shift_q;
  longint      energy_acc, virial_acc;
  bit          sat_hit;

  in_t  pending_pairs[$];
  out_t expected_results[$];
  int   fails = 0;
  int   cycles = 0;
  bit   tail_phase = 0;
  int   in_gap = 0, out_gap = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if ((p >> (64 + s)) != 0) begin
      sat_hit = 1;
      return '1;
    end
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] scale_by(logic [63:0] x, logic [63:0] k);
    if (x > (64'hFFFF_FFFF_FFFF_FFFF / k)) begin
      sat_hit = 1;
      return '1;
    end
    return x * k;
  endfunction

  function automatic longint to_signed(logic [63:0] mag, bit neg, logic [63:0] lim);
    if (mag > lim) begin
      sat_hit = 1;
      mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint add_clamped(longint a, longint b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sat_hit = 1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (t < -65'sh0_8000_0000_0000_0000) begin
      sat_hit = 1;
      return 64'sh8000_0000_0000_0000;
    end
    return longint'(t[63:0]);
  endfunction

  function automatic out_t pair_result(in_t p);
    out_t   r;
    longint d[3], f[3], len, a, b;
    logic [63:0] mag[3], rc2, r2, i2, i6, u, uu, twouu, em, gm, e4, c24, k, fm;
    logic [127:0] q;
    bit     in_cut, eneg, gneg;
    longint epair, vpair;
    sat_hit = 0;
    in_cut = 1;
    f = '{0, 0, 0};
    if (p.clear_sums) begin
      energy_acc = 0;
      virial_acc = 0;
    end
    len = longint'({33'd0, box_len});
    for (int i = 0; i < 3; i++) begin
      a = (i == 0) ? p.first_x : (i == 1) ? p.first_y : p.first_z;
      b = (i == 0) ? p.second_x : (i == 1) ? p.second_y : p.second_z;
      d[i] = b - a;
      if (2 * d[i] < -len) d[i] = d[i] + len;
      else if (2 * d[i] > len) d[i] = d[i] - len;
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      if (mag[i] > {33'd0, cut_rad}) in_cut = 0;
    end
    rc2 = {33'd0, cut_rad} * {33'd0, cut_rad};
    r2 = 0;
    if (in_cut) begin
      r2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      if (r2 > rc2) in_cut = 0;
    end
    if (in_cut) begin
      // Coincident atoms give a zero divisor and a saturated reciprocal.
      if (r2 == 0) begin
        sat_hit = 1;
        i2 = '1;
      end else begin
        q = (128'd1 << (32 + 2 * PFB)) / {64'd0, r2};
        if ((q >> 64) != 0) begin
          sat_hit = 1;
          i2 = '1;
        end else i2 = q[63:0];
      end
      i6 = mul_shift(mul_shift(i2, i2, 32), i2, 32);
      u = mul_shift({16'd0, sig6_q}, i6, 16);
      uu = mul_shift(u, u, 32);
      twouu = scale_by(uu, 2);
      eneg = uu < u;
      em = eneg ? u - uu : uu - u;
      e4 = scale_by(mul_shift({32'd0, eps_q}, em, 16), 4);
      epair = to_signed(e4, eneg, S64MAX);
      epair = add_clamped(epair, -(shift_q * 256));
      gneg = twouu < u;
      gm = gneg ? u - twouu : twouu - u;
      c24 = scale_by(mul_shift({32'd0, eps_q}, gm, 16), 24);
      vpair = to_signed(c24, !gneg, S64MAX);
      k = mul_shift(c24, i2, 32);
      for (int i = 0; i < 3; i++) begin
        fm = mul_shift(k, mag[i], 8 + PFB);
        f[i] = to_signed(fm, (!gneg) != (d[i] < 0), F47MAX);
      end
      energy_acc = add_clamped(energy_acc, epair);
      virial_acc = add_clamped(virial_acc, vpair);
    end
    r.force_x = f[0][47:0];
    r.force_y = f[1][47:0];
    r.force_z = f[2][47:0];
    r.within_cutoff = in_cut;
    r.energy_total = energy_acc;
    r.virial_total = virial_acc;
    r.saturated = sat_hit;
    return r;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(pair_result(in_data));
      if (!in_valid || !in_stall) begin
        if (!tail_phase && in_gap == 0 && $urandom_range(0, 7) == 0)
          in_gap = $urandom_range(1, 16);
        if (in_gap > 0 && !tail_phase) begin
          in_gap = in_gap - 1;
          in_valid <= 0;
        end else if (pending_pairs.size() > 0) begin
          in_gap = 0;
          in_valid <= 1;
          in_data <= pending_pairs.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Result monitor and output stall generator.
  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no pending request");
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.force_x !== e.force_x) begin
            $error("force_x expected %0d got %0d", e.force_x, out_data.force_x); fails++;
          end
          if (out_data.force_y !== e.force_y) begin
            $error("force_y expected %0d got %0d", e.force_y, out_data.force_y); fails++;
          end
          if (out_data.force_z !== e.force_z) begin
            $error("force_z expected %0d got %0d", e.force_z, out_data.force_z); fails++;
          end
          if (out_data.within_cutoff !== e.within_cutoff) begin
            $error("within_cutoff expected %0d got %0d", e.within_cutoff,
                   out_data.within_cutoff);
            fails++;
          end
          if (out_data.energy_total !== e.energy_total) begin
            $error("energy_total expected %0d got %0d", e.energy_total,
                   out_data.energy_total);
            fails++;
          end
          if (out_data.virial_total !== e.virial_total) begin
            $error("virial_total expected %0d got %0d", e.virial_total,
                   out_data.virial_total);
            fails++;
          end
          if (out_data.saturated !== e.saturated) begin
            $error("saturated expected %0d got %0d", e.saturated, out_data.saturated);
            fails++;
          end
        end
      end
      if (tail_phase) begin
        out_gap = 0;
        out_stall <= 0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_stall <= (out_gap != 0);
      end else if ($urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 16);
        out_stall <= 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_BOX:    box_len = val[30:0];
      CFG_CUTOFF: cut_rad = val[30:0];
      CFG_EPS:    eps_q = val[31:0];
      CFG_SIGMA6: sig6_q = val[47:0];
      CFG_ESHIFT: shift_q = {{16{val[47]}}, val[47:0]};
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t make_pair(bit clr, int fx, int fy, int fz,
                                    int sx, int sy, int sz);
    in_t p;
    p = '{clr, fx, fy, fz, sx, sy, sz};
    return p;
  endfunction

  function automatic in_t random_pair();
    in_t    p;
    longint reach, off;
    int     f[3], s[3];
    reach = (cut_rad > 31'h4000_0000) ? 64'h4000_0000 : cut_rad;
    reach = reach + reach / 4;
    for (int i = 0; i < 3; i++) begin
      f[i] = $urandom;
      if ($urandom_range(0, 9) < 8) begin
        off = longint'({$urandom, $urandom} % (2 * reach + 1)) - reach;
        if (off < 0) off = -off;
        if ($urandom_range(0, 1)) off = -off;
        if ($urandom_range(0, 5) == 0) off = off + ($urandom_range(0, 1) ? box_len : -box_len);
        s[i] = f[i] + int'(off);
      end else s[i] = $urandom;
    end
    p = make_pair($urandom_range(0, 29) == 0, f[0], f[1], f[2], s[0], s[1], s[2]);
    return p;
  endfunction

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = CFG_BOX;
    cfg_data = 0;
    in_data = '0;
    box_len = BOX_RST;
    cut_rad = CUTOFF_RST;
    eps_q = EPS_RST;
    sig6_q = SIGMA6_RST;
    shift_q = {{16{ESHIFT_RST[47]}}, ESHIFT_RST};
    energy_acc = 0;
    virial_acc = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed pairs at the default box of 10.0 and cutoff of 2.5.
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 163840, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 163841, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -163840, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 65536, 65536, 65536));
    pending_pairs.push_back(make_pair(0, -294912, 0, 0, 294912, 0, 0));
    pending_pairs.push_back(make_pair(0, 294912, 0, 0, -294912, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 327680, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, -327680, 0, 0));
    pending_pairs.push_back(make_pair(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 32768, 0, 0));
    pending_pairs.push_back(make_pair(0, 100, 200, 300, 100 + 1, 200, 300));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 70000, -70000));
    pending_pairs.push_back(make_pair(0, 65536, 0, 0, 65536 + 72000, 0, 0));
    pending_pairs.push_back(make_pair(0, -1, -1, -1, -1, -1, -1));
    for (int i = 0; i < PER_PHASE; i++) pending_pairs.push_back(random_pair());
    drain();

    for (int ph = 1; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_BOX, 64'h7FFF_FFFF);
          write_reg(CFG_CUTOFF, 64'h7FFF_FFFF);
          write_reg(CFG_EPS, 64'hFFFF_FFFF);
          write_reg(CFG_SIGMA6, 64'hFFFF_FFFF_FFFF);
          write_reg(CFG_ESHIFT, 64'h7FFF_FFFF_FFFF);
        end
        2: begin
          write_reg(CFG_BOX, 0);
          write_reg(CFG_CUTOFF, 0);
          write_reg(CFG_EPS, 0);
          write_reg(CFG_SIGMA6, 0);
          write_reg(CFG_ESHIFT, 64'h8000_0000_0000);
        end
        default: begin
          write_reg(CFG_BOX, {rand64() % 64'h0010_0000} + 64'h0002_0000);
          write_reg(CFG_CUTOFF, {32'd0, $urandom_range(4096, 64'd1 << 19)});
          write_reg(CFG_EPS, {$urandom, $urandom_range(0, 1 << 18)});
          write_reg(CFG_SIGMA6, {$urandom, 32'($urandom_range(0, 1 << 20))});
          write_reg(CFG_ESHIFT, {$urandom, $urandom_range(0, 1 << 22)}
                                ^ ($urandom_range(0, 1) ? 64'hFFFF_FFFF_FF00_0000 : 64'd0));
        end
      endcase
      for (int i = 0; i < PER_PHASE; i++) pending_pairs.push_back(random_pair());
      if (ph == 5) begin
        wait (pending_pairs.size() < 80);
        tail_phase = 1;
      end
      drain();
    end

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ljpf_pkg.sv
rtl/ljpf_mul.sv
rtl/ljpf_div.sv
rtl/ljpf_dp.sv
rtl/ljpf_ctrl.sv
rtl/lj_pair_force_periodic.sv
test/lj_pair_force_periodic_test.sv
